/* src/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define SNLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("snlp assertion failed");

// Clocked assertion that also holds through reset.
`define SNLP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("snlp assertion failed");

`endif

/* src/snlp_pkg.sv */
// Types, constants and character decode for the suffixed literal parser.
package snlp_pkg;

  localparam int ValueBits  = 32;
  localparam int OutBits    = 32;
  localparam int RadixCount = 4;
  localparam int DigitBits  = 4;

  typedef enum logic [1:0] {
    RadixDec,
    RadixOct,
    RadixBin,
    RadixHex
  } radix_e;

  localparam logic [7:0] CharD    = 8'h44;
  localparam logic [7:0] CharO    = 8'h4F;
  localparam logic [7:0] CharB    = 8'h42;
  localparam logic [7:0] CharH    = 8'h48;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpF  = 8'h46;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowZ = 8'h7A;
  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [DigitBits-1:0] HexTen = 4'd10;

  // One decoded character on its way into the accumulators.
  typedef struct packed {
    logic                 fire;
    logic                 last;
    logic                 suffix;
    radix_e               sel;
    logic                 is_digit;
    logic [DigitBits-1:0] digit;
  } step_t;

  typedef struct packed {
    logic               ok;
    logic [OutBits-1:0] value;
  } result_t;

  function automatic step_t decode_char(logic [7:0] code, logic last);
    logic [7:0] c;
    step_t      s;
    c = code;
    if (c >= CharLowA && c <= CharLowZ) begin
      c = c & ~CaseBit;
    end
    s.fire     = 1'b0;
    s.last     = last;
    s.is_digit = 1'b0;
    s.digit    = '0;
    if (c >= CharZero && c <= CharNine) begin
      s.is_digit = 1'b1;
      s.digit    = DigitBits'(c - CharZero);
    end else if (c >= CharUpA && c <= CharUpF) begin
      s.is_digit = 1'b1;
      s.digit    = DigitBits'(c - CharUpA) + HexTen;
    end
    s.suffix = 1'b1;
    case (c)
      CharD:   s.sel = RadixDec;
      CharO:   s.sel = RadixOct;
      CharB:   s.sel = RadixBin;
      CharH:   s.sel = RadixHex;
      default: begin
        s.sel    = RadixDec;
        s.suffix = 1'b0;
      end
    endcase
    return s;
  endfunction

endpackage

/* src/snlp_accum.sv */
// Per-radix accumulators and digit-valid flags, with result selection.
module snlp_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  snlp_pkg::step_t   step_i,
  output snlp_pkg::result_t result_o
);
  import snlp_pkg::*;

  logic [ValueBits-1:0]  acc_q   [RadixCount];
  logic [ValueBits-1:0]  acc_fed [RadixCount];
  logic [ValueBits-1:0]  acc_nxt [RadixCount];
  logic [RadixCount-1:0] ok_q, ok_fed, feed, legal;
  logic [ValueBits-1:0]  dig_ext;

  assign dig_ext = ValueBits'(step_i.digit);

  // Constant multiplies reduce to shifts and one add (two for decimal).
  always_comb begin
    acc_nxt[RadixDec] = (acc_q[RadixDec] << 3) + (acc_q[RadixDec] << 1) + dig_ext;
    acc_nxt[RadixOct] = (acc_q[RadixOct] << 3) + dig_ext;
    acc_nxt[RadixBin] = (acc_q[RadixBin] << 1) + dig_ext;
    acc_nxt[RadixHex] = (acc_q[RadixHex] << 4) + dig_ext;
  end

  always_comb begin
    legal[RadixDec] = step_i.is_digit && (step_i.digit <= 4'd9);
    legal[RadixOct] = step_i.is_digit && (step_i.digit <= 4'd7);
    legal[RadixBin] = step_i.is_digit && (step_i.digit <= 4'd1);
    legal[RadixHex] = step_i.is_digit;
    // a final non-suffix char is one more decimal digit
    feed            = {RadixCount{step_i.fire && !step_i.last}};
    feed[RadixDec]  = step_i.fire && !(step_i.last && step_i.suffix);
  end

  always_comb begin
    for (int r = 0; r < RadixCount; r++) begin
      acc_fed[r] = acc_q[r];
      ok_fed[r]  = ok_q[r];
      if (feed[r] && ok_q[r]) begin
        if (legal[r]) begin
          acc_fed[r] = acc_nxt[r];
        end else begin
          ok_fed[r] = 1'b0;
        end
      end
    end
  end

  assign result_o.ok    = ok_fed[step_i.sel];
  assign result_o.value = OutBits'(acc_fed[step_i.sel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= '1;
      for (int r = 0; r < RadixCount; r++) begin
        acc_q[r] <= '0;
      end
    end else if (step_i.fire) begin
      if (step_i.last) begin
        ok_q <= '1;
        for (int r = 0; r < RadixCount; r++) begin
          acc_q[r] <= '0;
        end
      end else begin
        ok_q <= ok_fed;
        for (int r = 0; r < RadixCount; r++) begin
          acc_q[r] <= acc_fed[r];
        end
      end
    end
  end

endmodule

/* src/suffixed_number_literal_parser.sv */
// Top level of the suffixed numeric literal parser.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------
//   in      | in_valid_i/in_ready_o | char_code_i, last_char_i
//   out     | out_valid_o/out_ready_i | value_ok_o, value_o
//
// One character word per cycle while no final character is held; a result word is
// registered after its final character is taken (input register at the accepting
// edge, then the result register once that character advances).
// The accumulator update is a shift-and-add per radix between those registers.
// Reset zeroes all accumulators and sets every digit-ok flag; the next literal starts fresh.
// A final character waits in the input register only while the result
// register is full and not being drained; other characters never wait.
module suffixed_number_literal_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        value_ok_o,
  output logic [31:0] value_o
);
  import snlp_pkg::*;

  logic               in_valid_q, in_valid_d;
  logic [7:0]         char_q;
  logic               last_q;
  logic               advance;
  logic               out_valid_q, out_valid_d;
  logic               ok_q;
  logic [OutBits-1:0] value_q;
  step_t              step;
  result_t            result;

  assign advance    = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_comb begin
    step      = decode_char(char_q, last_q);
    step.fire = advance;
  end

  snlp_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    if (advance && last_q) begin
      ok_q    <= result.ok;
      value_q <= result.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_ok_o  = ok_q;
  assign value_o     = value_q;

endmodule

/* src/snlp_checker.sv */
// Port-level checks for the suffixed literal parser, bound to the top level.
`include "assert_macros.svh"

module snlp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_char_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        value_ok_o,
  input logic [31:0] value_o
);

  `SNLP_ASSERT(out_valid_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `SNLP_ASSERT(out_word_stable, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> $stable(value_o) && $stable(value_ok_o))
  `SNLP_ASSERT(result_from_last, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_char_i, 2))
  `SNLP_ASSERT(stall_only_on_full_out, clk_i, rst_ni,
    !in_ready_o |-> out_valid_o && !out_ready_i)

endmodule

bind suffixed_number_literal_parser snlp_checker u_snlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_char_i (last_char_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_ok_o  (value_ok_o),
  .value_o     (value_o)
);

/* sim/tb.sv */
// Testbench for the suffixed numeric literal parser: predictor, scoreboard and drivers.

class literal_scoreboard;
  logic [snlp_pkg::OutBits-1:0] acc[snlp_pkg::RadixCount];
  logic [snlp_pkg::RadixCount-1:0] digits_ok;
  snlp_pkg::result_t result_q[$];
  int errors;

  function new();
    errors = 0;
    clear_literal();
  endfunction

  static function int unsigned base_of(snlp_pkg::radix_e r);
    case (r)
      snlp_pkg::RadixDec: return 10;
      snlp_pkg::RadixOct: return 8;
      snlp_pkg::RadixBin: return 2;
      default:            return 16;
    endcase
  endfunction

  function void clear_literal();
    for (int r = 0; r < snlp_pkg::RadixCount; r++) acc[r] = '0;
    digits_ok = '1;
  endfunction

  function int pending();
    return result_q.size();
  endfunction

  // 255 marks a character that is no digit in any radix
  function logic [7:0] digit_of(logic [7:0] c);
    if (c >= snlp_pkg::CharZero && c <= snlp_pkg::CharNine) return c - snlp_pkg::CharZero;
    if (c >= snlp_pkg::CharUpA && c <= snlp_pkg::CharUpF) return c - snlp_pkg::CharUpA + 8'd10;
    return 8'hFF;
  endfunction

  // frozen once the first illegal digit for this radix is seen
  function void feed(snlp_pkg::radix_e r, logic [7:0] d);
    int unsigned base;
    base = base_of(r);
    if (!digits_ok[r]) return;
    if (32'(d) >= base) digits_ok[r] = 1'b0;
    else acc[r] = acc[r] * base + 32'(d);
  endfunction

  function void note_char(logic [7:0] code, logic last);
    logic [7:0] c;
    logic [7:0] d;
    snlp_pkg::radix_e sel;
    snlp_pkg::result_t res;
    c = code;
    if (c >= snlp_pkg::CharLowA && c <= snlp_pkg::CharLowZ) c = c - snlp_pkg::CaseBit;
    d = digit_of(c);
    if (!last) begin
      for (int r = 0; r < snlp_pkg::RadixCount; r++) feed(snlp_pkg::radix_e'(r), d);
      return;
    end
    // a suffix on the final character is not a digit
    case (c)
      snlp_pkg::CharD: sel = snlp_pkg::RadixDec;
      snlp_pkg::CharO: sel = snlp_pkg::RadixOct;
      snlp_pkg::CharB: sel = snlp_pkg::RadixBin;
      snlp_pkg::CharH: sel = snlp_pkg::RadixHex;
      default: begin
        sel = snlp_pkg::RadixDec;
        feed(snlp_pkg::RadixDec, d);
      end
    endcase
    res.ok    = digits_ok[sel];
    res.value = acc[sel];
    result_q.push_back(res);
    clear_literal();
  endfunction

  task report(string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_word(logic ok, logic [snlp_pkg::OutBits-1:0] value);
    snlp_pkg::result_t want;
    if (result_q.size() == 0) begin
      report($sformatf("result word ok=%0b value=%08h with none expected", ok, value));
      return;
    end
    want = result_q.pop_front();
    if (ok !== want.ok)
      report($sformatf("value_ok %0b, expected %0b", ok, want.ok));
    if (value !== want.value)
      report($sformatf("value %08h, expected %08h", value, want.value));
  endtask
endclass

module tb;
  import snlp_pkg::*;

  localparam int NumChars    = 500;
  localparam int QuietFrom   = 420;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = '0;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        value_ok_o;
  logic [31:0] value_o;

  literal_scoreboard sb = new();

  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int chars_sent;
  int literals_sent;
  int words_checked;
  int quiet_cycles;

  suffixed_number_literal_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_ok_o  (value_ok_o),
    .value_o     (value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [7:0] digit_char(int unsigned v, bit lower);
    if (v < 10) return CharZero + 8'(v);
    return (lower ? CharLowA : CharUpA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] suffix_char(radix_e r);
    case (r)
      RadixDec: return CharD;
      RadixOct: return CharO;
      RadixBin: return CharB;
      default:  return CharH;
    endcase
  endfunction

  task automatic send_char(logic [7:0] code, logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(code, last);
    chars_sent++;
    if (last) literals_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic random_literal();
    int unsigned n;
    int bad_at;
    radix_e r;
    logic [7:0] c;
    if ($urandom_range(0, 9) >= 8) begin
      // noise: arbitrary bytes, any of them can be the final one
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
      return;
    end
    r = radix_e'($urandom_range(0, 3));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 6);
    bad_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, n)) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) c = 8'($urandom_range(0, 255));
      else c = digit_char($urandom_range(0, sb.base_of(r) - 1),
                          1'($urandom_range(0, 1)));
      send_char(c, 1'b0);
    end
    if (r == RadixDec && $urandom_range(0, 2) == 0)
      send_char(digit_char($urandom_range(0, 9), 1'b0), 1'b1);
    else
      send_char(suffix_char(r) | ($urandom_range(0, 1) ? CaseBit : 8'h00), 1'b1);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(value_ok_o, value_o);
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: no handshake for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    send_text("H");           // suffix only
    send_text("7fh");         // lower case digit and suffix
    send_text("109");         // final plain digit goes to decimal
    send_text("178o");        // illegal octal digit
    send_text("12b");         // illegal binary digit
    send_text("FFFFFFFFFH");  // wraps past 32 bits
    send_char(8'hFF, 1'b0);   // non-ASCII bytes
    send_char(8'h80, 1'b1);

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    while (chars_sent < NumChars) begin
      if (!paused && chars_sent >= 250) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      if (chars_sent >= QuietFrom) gaps_on = 1'b0;
      random_literal();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("tb: %0d characters in %0d literals, %0d result words compared",
             chars_sent, literals_sent, words_checked);
    $display("tb: all radixes and suffix cases, wrap, bad digits and noise bytes");
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
